>>> rtl/med_pkg.sv
// Shared types, event codes and constants of the multitouch event decoder.
`timescale 1ns / 1ps
`default_nettype none

package med_pkg;

	localparam int SLOT_COUNT      = 2;
	localparam int SCALE_FRAC_BITS = 16;

	localparam int SLOT_W      = $clog2(SLOT_COUNT + 1);
	localparam int CNT_W       = (SLOT_W < 2) ? 2 : SLOT_W;
	localparam int SECOND_SLOT = (SLOT_COUNT > 1) ? 1 : 0;
	localparam bit HAS_SECOND  = (SLOT_COUNT > 1);

	localparam logic [SLOT_W-1:0] NO_SLOT = SLOT_W'(SLOT_COUNT);

	localparam int PP_LO_W = SCALE_FRAC_BITS + 32;
	localparam int Q_W     = 64 - SCALE_FRAC_BITS;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	localparam int IN_USER_W = 32;
	localparam int IN_DATA_W = 32;
	localparam int OUT_DATA_W = 136;

	localparam logic [31:0] EMPTY_ID = 32'hFFFF_FFFF;

	localparam logic [15:0] EV_SYN             = 16'd0;
	localparam logic [15:0] EV_MSC             = 16'd4;
	localparam logic [15:0] SYN_REPORT         = 16'd0;
	localparam logic [15:0] SYN_MT_REPORT      = 16'd2;
	localparam logic [15:0] MSC_RAW            = 16'd3;
	localparam logic [15:0] MSC_SKIP           = 16'd4;
	localparam logic [15:0] CODE_SLOT_SELECT   = 16'd47;
	localparam logic [15:0] ABS_MT_POSITION_X  = 16'd53;
	localparam logic [15:0] ABS_MT_POSITION_Y  = 16'd54;
	localparam logic [15:0] CODE_TRACK_ID      = 16'd57;

	localparam logic [2:0] CFG_RAW_MIN_X     = 3'd0;
	localparam logic [2:0] CFG_RAW_MIN_Y     = 3'd1;
	localparam logic [2:0] CFG_SCALE_X       = 3'd2;
	localparam logic [2:0] CFG_SCALE_Y       = 3'd3;
	localparam logic [2:0] CFG_AXIS_FLAGS    = 3'd4;
	localparam logic [2:0] CFG_SCREEN_WIDTH  = 3'd5;
	localparam logic [2:0] CFG_SCREEN_HEIGHT = 3'd6;

	typedef enum logic [2:0] {
		OP_REPORT,
		OP_CONTACT,
		OP_SLOT,
		OP_ID,
		OP_X,
		OP_Y
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [31:0] value;
	} cmd_t;

	typedef struct packed {
		logic [31:0] raw_min_x;
		logic [31:0] raw_min_y;
		logic [31:0] scale_x;
		logic [31:0] scale_y;
		logic [2:0]  axis_flags;
		logic [15:0] screen_width;
		logic [15:0] screen_height;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  fingers;
		logic        pres0;
		logic [31:0] id0;
		logic        pres1;
		logic [31:0] id1;
	} frame_side_t;

endpackage

`default_nettype wire

>>> rtl/med_front.sv
// Front end: accepts input events and classifies them into decoder commands.
`timescale 1ns / 1ps
`default_nettype none

module med_front
	import med_pkg::*;
(
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [IN_USER_W-1:0] s_tuser,
	input  wire logic [IN_DATA_W-1:0] s_tdata,
	input  wire logic                 fifo_full,
	output logic                      push,
	output cmd_t                      push_cmd
);

	logic [15:0] ev_type;
	logic [15:0] ev_code;
	logic [31:0] ev_value;
	logic        keep;
	logic        slot_ok;

	assign ev_type  = s_tuser[15:0];
	assign ev_code  = s_tuser[31:16];
	assign ev_value = s_tdata[31:0];
	assign s_tready = !fifo_full;
	assign push     = s_tvalid && s_tready && keep;
	assign slot_ok  = !ev_value[31] && (ev_value < 32'(SLOT_COUNT));

	always_comb begin
		keep           = 1'b0;
		push_cmd.op    = OP_REPORT;
		push_cmd.value = ev_value;
		if (ev_type == EV_SYN) begin
			case (ev_code)
				SYN_REPORT: begin
					keep        = 1'b1;
					push_cmd.op = OP_REPORT;
				end
				SYN_MT_REPORT: begin
					keep        = 1'b1;
					push_cmd.op = OP_CONTACT;
				end
				default: keep = 1'b0;
			endcase
		end else if (!(ev_type == EV_MSC && (ev_code inside {MSC_RAW, MSC_SKIP}))) begin
			case (ev_code)
				CODE_SLOT_SELECT: begin
					keep           = 1'b1;
					push_cmd.op    = OP_SLOT;
					push_cmd.value = {{(32 - SLOT_W){1'b0}},
						(slot_ok ? ev_value[SLOT_W-1:0] : NO_SLOT)};
				end
				CODE_TRACK_ID: begin
					keep        = 1'b1;
					push_cmd.op = OP_ID;
				end
				ABS_MT_POSITION_X: begin
					keep        = 1'b1;
					push_cmd.op = OP_X;
				end
				ABS_MT_POSITION_Y: begin
					keep        = 1'b1;
					push_cmd.op = OP_Y;
				end
				default: keep = 1'b0;
			endcase
		end
	end

endmodule

`default_nettype wire

>>> rtl/med_fifo.sv
// Short command queue between the front end and the back end.
`timescale 1ns / 1ps
`default_nettype none

module med_fifo
	import med_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  cmd_t      push_cmd,
	output logic      full,
	input  wire logic pop,
	output cmd_t      pop_cmd,
	output logic      not_empty
);

	cmd_t                  entry_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_CNT_W-1:0] count_q;

	assign full      = (count_q == FIFO_CNT_W'(FIFO_DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_cmd   = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + FIFO_CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - FIFO_CNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/med_calib.sv
// One calibration lane: offset, fixed-point scaling, mirroring and clamping of one axis.
`timescale 1ns / 1ps
`default_nettype none

module med_calib
	import med_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        en,
	input  wire logic [31:0] raw_s1,
	input  wire logic [31:0] min_val,
	input  wire logic [31:0] scale,
	input  wire logic        mirror,
	input  wire logic [15:0] size,
	output logic [15:0]      result
);

	logic [32:0]        d_s2;
	logic               neg_s3;
	logic [31:0]        mag_s3;
	logic               neg_s4;
	logic [PP_LO_W-1:0] pp_lo_s4;
	logic [Q_W-1:0]     pp_hi_s4;
	logic               neg_s5;
	logic [Q_W-1:0]     q_s5;
	logic               big;
	logic [15:0]        diff;

	always_ff @(posedge clk) begin
		if (en) begin
			d_s2     <= {raw_s1[31], raw_s1} - {min_val[31], min_val};
			neg_s3   <= d_s2[32];
			mag_s3   <= d_s2[32] ? 32'(~d_s2 + 33'd1) : d_s2[31:0];
			neg_s4   <= neg_s3;
			pp_lo_s4 <= PP_LO_W'(mag_s3[SCALE_FRAC_BITS-1:0]) * PP_LO_W'(scale);
			pp_hi_s4 <= Q_W'(mag_s3[31:SCALE_FRAC_BITS]) * Q_W'(scale);
			neg_s5   <= neg_s4;
			q_s5     <= pp_hi_s4 + Q_W'(pp_lo_s4 >> SCALE_FRAC_BITS);
		end
	end

	assign big  = (q_s5 > Q_W'(size));
	assign diff = size - q_s5[15:0];

	always_comb begin
		if (mirror) begin
			result = neg_s5 ? size : (big ? 16'd0 : diff);
		end else begin
			result = neg_s5 ? 16'd0 : (big ? size : q_s5[15:0]);
		end
	end

endmodule

`default_nettype wire

>>> rtl/med_back.sv
// Back end: slot state, contact matching, frame snapshot and calibration pipeline.
`timescale 1ns / 1ps
`default_nettype none

module med_back
	import med_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  cfg_t                       cfg,
	input  wire logic                  cmd_valid,
	input  cmd_t                       cmd,
	output logic                       cmd_pop,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [OUT_DATA_W-1:0]      m_tdata
);

	logic                  slot_mode_q;
	logic [SLOT_W-1:0]     sel_q;
	logic [31:0]           pend_id_q;
	logic [31:0]           pend_x_q;
	logic [31:0]           pend_y_q;
	logic [31:0]           slot_id_q   [SLOT_COUNT];
	logic [31:0]           slot_x_q    [SLOT_COUNT];
	logic [31:0]           slot_y_q    [SLOT_COUNT];
	logic [SLOT_COUNT-1:0] refr_q;

	logic [SLOT_COUNT-1:0] match_vec;
	logic [SLOT_COUNT-1:0] empty_vec;
	logic [SLOT_COUNT-1:0] tgt_vec;
	logic                  found;
	logic                  free;
	logic [31:0]           rep_id [SLOT_COUNT];
	logic [CNT_W-1:0]      cnt;
	logic [1:0]            fingers;
	logic                  en;
	logic                  rep_pop;
	logic                  exch;

	logic                  v_s1, v_s2, v_s3, v_s4, v_s5;
	frame_side_t           side_s1, side_s2, side_s3, side_s4, side_s5;
	logic [31:0]           rx0_s1, ry0_s1, rx1_s1, ry1_s1;
	logic [15:0]           x0, y0, x1, y1;
	logic                  out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;

	assign en      = !out_valid_q || m_tready;
	assign cmd_pop = cmd_valid && ((cmd.op != OP_REPORT) || en);
	assign rep_pop = cmd_pop && (cmd.op == OP_REPORT);
	assign exch    = cfg.axis_flags[2];

	always_comb begin
		match_vec = '0;
		empty_vec = '0;
		found     = 1'b0;
		free      = 1'b0;
		for (int i = 0; i < SLOT_COUNT; i++) begin
			if (!found && slot_id_q[i] == pend_id_q) begin
				match_vec[i] = 1'b1;
				found        = 1'b1;
			end
		end
		for (int i = 0; i < SLOT_COUNT; i++) begin
			if (!free && slot_id_q[i] == EMPTY_ID) begin
				empty_vec[i] = 1'b1;
				free         = 1'b1;
			end
		end
		tgt_vec = found ? match_vec : empty_vec;
	end

	always_comb begin
		cnt = '0;
		for (int i = 0; i < SLOT_COUNT; i++) begin
			rep_id[i] = (!slot_mode_q && !refr_q[i]) ? EMPTY_ID : slot_id_q[i];
			if (rep_id[i] != EMPTY_ID) begin
				cnt = cnt + CNT_W'(1);
			end
		end
		fingers = (cnt > CNT_W'(3)) ? 2'd3 : cnt[1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_mode_q <= 1'b1;
			sel_q       <= '0;
			pend_id_q   <= EMPTY_ID;
			pend_x_q    <= EMPTY_ID;
			pend_y_q    <= EMPTY_ID;
			refr_q      <= '0;
			for (int i = 0; i < SLOT_COUNT; i++) begin
				slot_id_q[i] <= EMPTY_ID;
				slot_x_q[i]  <= '0;
				slot_y_q[i]  <= '0;
			end
		end else if (cmd_pop) begin
			case (cmd.op)
				OP_SLOT: begin
					slot_mode_q <= 1'b1;
					sel_q       <= cmd.value[SLOT_W-1:0];
				end
				OP_ID: begin
					if (!slot_mode_q) begin
						pend_id_q <= cmd.value;
					end else begin
						for (int i = 0; i < SLOT_COUNT; i++) begin
							if (sel_q == SLOT_W'(i)) begin
								slot_id_q[i] <= cmd.value;
							end
						end
					end
				end
				OP_X: begin
					if (!slot_mode_q) begin
						pend_x_q <= cmd.value;
					end else begin
						for (int i = 0; i < SLOT_COUNT; i++) begin
							if (sel_q == SLOT_W'(i)) begin
								slot_x_q[i] <= cmd.value;
							end
						end
					end
				end
				OP_Y: begin
					if (!slot_mode_q) begin
						pend_y_q <= cmd.value;
					end else begin
						for (int i = 0; i < SLOT_COUNT; i++) begin
							if (sel_q == SLOT_W'(i)) begin
								slot_y_q[i] <= cmd.value;
							end
						end
					end
				end
				OP_CONTACT: begin
					if (slot_mode_q) begin
						slot_mode_q <= 1'b0;
						sel_q       <= NO_SLOT;
					end else begin
						for (int i = 0; i < SLOT_COUNT; i++) begin
							if (tgt_vec[i]) begin
								refr_q[i]   <= 1'b1;
								slot_x_q[i] <= pend_x_q;
								slot_y_q[i] <= pend_y_q;
								if (!found) begin
									slot_id_q[i] <= pend_id_q;
								end
							end
						end
					end
				end
				OP_REPORT: begin
					if (!slot_mode_q) begin
						refr_q    <= '0;
						pend_id_q <= EMPTY_ID;
						for (int i = 0; i < SLOT_COUNT; i++) begin
							slot_id_q[i] <= rep_id[i];
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1.fingers <= fingers;
			side_s1.pres0   <= (rep_id[0] != EMPTY_ID);
			side_s1.id0     <= rep_id[0];
			side_s1.pres1   <= HAS_SECOND && (rep_id[SECOND_SLOT] != EMPTY_ID);
			side_s1.id1     <= HAS_SECOND ? rep_id[SECOND_SLOT] : EMPTY_ID;
			rx0_s1          <= exch ? slot_y_q[0] : slot_x_q[0];
			ry0_s1          <= exch ? slot_x_q[0] : slot_y_q[0];
			rx1_s1          <= exch ? slot_y_q[SECOND_SLOT] : slot_x_q[SECOND_SLOT];
			ry1_s1          <= exch ? slot_x_q[SECOND_SLOT] : slot_y_q[SECOND_SLOT];
			side_s2         <= side_s1;
			side_s3         <= side_s2;
			side_s4         <= side_s3;
			side_s5         <= side_s4;
			if (v_s5) begin
				out_data_q <= {4'd0,
					(side_s5.pres1 ? y1 : 16'd0), (side_s5.pres1 ? x1 : 16'd0),
					side_s5.id1, side_s5.pres1,
					(side_s5.pres0 ? y0 : 16'd0), (side_s5.pres0 ? x0 : 16'd0),
					side_s5.id0, side_s5.pres0, side_s5.fingers};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			v_s5        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_s1        <= rep_pop;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			v_s4        <= v_s3;
			v_s5        <= v_s4;
			out_valid_q <= v_s5;
		end
	end

	med_calib u_calib_x0 (
		.clk     (clk),
		.en      (en),
		.raw_s1  (rx0_s1),
		.min_val (cfg.raw_min_x),
		.scale   (cfg.scale_x),
		.mirror  (cfg.axis_flags[0]),
		.size    (cfg.screen_width),
		.result  (x0)
	);

	med_calib u_calib_y0 (
		.clk     (clk),
		.en      (en),
		.raw_s1  (ry0_s1),
		.min_val (cfg.raw_min_y),
		.scale   (cfg.scale_y),
		.mirror  (cfg.axis_flags[1]),
		.size    (cfg.screen_height),
		.result  (y0)
	);

	med_calib u_calib_x1 (
		.clk     (clk),
		.en      (en),
		.raw_s1  (rx1_s1),
		.min_val (cfg.raw_min_x),
		.scale   (cfg.scale_x),
		.mirror  (cfg.axis_flags[0]),
		.size    (cfg.screen_width),
		.result  (x1)
	);

	med_calib u_calib_y1 (
		.clk     (clk),
		.en      (en),
		.raw_s1  (ry1_s1),
		.min_val (cfg.raw_min_y),
		.scale   (cfg.scale_y),
		.mirror  (cfg.axis_flags[1]),
		.size    (cfg.screen_height),
		.result  (y1)
	);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

`default_nettype wire

>>> rtl/multitouch_event_decoder.sv
// Top level of the multitouch event decoder: configuration registers and block wiring.
//
//  Channel  Direction  Request contents
//  s_*      in         one input event: type and code in tuser, value in tdata
//  m_*      out        one frame per report sync: count, two slots with id and x/y
//  cfg_*    in         one register write: index and data, no wait
//
//  An event is accepted every cycle while the four-entry command queue has room.
//  The back end executes one command per cycle unless a stalled output holds
//  a report command. A report sync accepted into an empty queue reaches m_tdata
//  through the pop into the first of five pipeline stages, four more stages and
//  the output register. A stalled output halts only the calibration pipeline and
//  report commands. Reset is asynchronous and needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module multitouch_event_decoder
	import med_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	// s_tuser: event_type [15:0], event_code [31:16]
	input  wire logic [IN_USER_W-1:0]  s_tuser,
	// s_tdata: event_value [31:0]
	input  wire logic [IN_DATA_W-1:0]  s_tdata,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	// m_tdata: fingers_down, first_present, first_id, first_x, first_y,
	// second_present, second_id, second_x, second_y, zero padding
	output logic [OUT_DATA_W-1:0]      m_tdata,
	input  wire logic                  cfg_we,
	input  wire logic [2:0]            cfg_index,
	input  wire logic [31:0]           cfg_wdata
);

	cfg_t cfg_q;
	cmd_t push_cmd;
	cmd_t pop_cmd;
	logic fifo_push;
	logic fifo_full;
	logic fifo_nempty;
	logic cmd_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.raw_min_x     <= 32'd0;
			cfg_q.raw_min_y     <= 32'd0;
			cfg_q.scale_x       <= 32'd1 << SCALE_FRAC_BITS;
			cfg_q.scale_y       <= 32'd1 << SCALE_FRAC_BITS;
			cfg_q.axis_flags    <= 3'd0;
			cfg_q.screen_width  <= 16'd1024;
			cfg_q.screen_height <= 16'd768;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_RAW_MIN_X:     cfg_q.raw_min_x     <= cfg_wdata;
				CFG_RAW_MIN_Y:     cfg_q.raw_min_y     <= cfg_wdata;
				CFG_SCALE_X:       cfg_q.scale_x       <= cfg_wdata;
				CFG_SCALE_Y:       cfg_q.scale_y       <= cfg_wdata;
				CFG_AXIS_FLAGS:    cfg_q.axis_flags    <= cfg_wdata[2:0];
				CFG_SCREEN_WIDTH:  cfg_q.screen_width  <= cfg_wdata[15:0];
				CFG_SCREEN_HEIGHT: cfg_q.screen_height <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	med_front u_front (
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tuser   (s_tuser),
		.s_tdata   (s_tdata),
		.fifo_full (fifo_full),
		.push      (fifo_push),
		.push_cmd  (push_cmd)
	);

	med_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (fifo_push),
		.push_cmd  (push_cmd),
		.full      (fifo_full),
		.pop       (cmd_pop),
		.pop_cmd   (pop_cmd),
		.not_empty (fifo_nempty)
	);

	med_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd_valid (fifo_nempty),
		.cmd       (pop_cmd),
		.cmd_pop   (cmd_pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

`ifndef SYNTHESIS
	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_push |-> !fifo_full)
		else $error("command pushed into a full queue");

	a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> fifo_nempty)
		else $error("command popped from an empty queue");

	a_full_stays_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_full |=> fifo_nempty)
		else $error("queue drained by more than one entry in a cycle");
`endif

endmodule

`default_nettype wire
